>>> design/rmpq_pkg.sv
// Shared constants and width helpers for the rotation matrix to pose quaternion unit.
`timescale 1ns / 1ps
`default_nettype none

package rmpq_pkg;

  localparam int unsigned MAT_W = 16;
  localparam int unsigned QW_W = 15;
  localparam int unsigned QV_W = 16;
  localparam int unsigned LANES = 4;
  localparam int unsigned DEF_FRAC_BITS = 14;
  localparam int unsigned DEF_SHIFT_W = 24;

  // Signed width of a sum of three matrix entries.
  localparam int unsigned SUM_W = MAT_W + 2;

  // Lane order of the square root chain.
  localparam int unsigned LANE_W = 0;
  localparam int unsigned LANE_X = 1;
  localparam int unsigned LANE_Y = 2;
  localparam int unsigned LANE_Z = 3;

  // Signed width of one plus a sum of three entries.
  function automatic int unsigned rad_w(input int unsigned frac);
    rad_w = ((frac + 1 > SUM_W) ? frac + 1 : SUM_W) + 1;
  endfunction

  // Width of the positive radicand after scaling by 2^(frac-2).
  function automatic int unsigned nrad_w(input int unsigned frac);
    nrad_w = rad_w(frac) - 1 + frac - 2;
  endfunction

  // Number of root bits, one per cell of the chain.
  function automatic int unsigned root_w(input int unsigned frac);
    root_w = (nrad_w(frac) + 1) / 2;
  endfunction

endpackage

`default_nettype wire

>>> design/rmpq_radicand.sv
// Forms one clamped and scaled square root radicand from the matrix diagonal.
`timescale 1ns / 1ps
`default_nettype none

module rmpq_radicand import rmpq_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS,
  parameter bit NEG_A = 1'b0,
  parameter bit NEG_B = 1'b0,
  parameter bit NEG_C = 1'b0
) (
  input  logic signed [MAT_W-1:0]             a,
  input  logic signed [MAT_W-1:0]             b,
  input  logic signed [MAT_W-1:0]             c,
  output logic        [nrad_w(FRAC_BITS)-1:0] n
);

  localparam int unsigned SW = rad_w(FRAC_BITS);
  localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  logic signed [SUM_W-1:0] ae, be, ce, d;
  logic signed [SW-1:0]    s;

  always_comb begin
    ae = SUM_W'(a);
    be = SUM_W'(b);
    ce = SUM_W'(c);
    d = (NEG_A ? -ae : ae) + (NEG_B ? -be : be) + (NEG_C ? -ce : ce);
    s = SW'(d) + ONE_S;
    // A radicand at or below zero gives a zero magnitude.
    if (!s[SW-1] && (s != '0)) begin
      n = {s[SW-2:0], {(FRAC_BITS-2){1'b0}}};
    end else begin
      n = '0;
    end
  end

endmodule

`default_nettype wire

>>> design/rmpq_root_cell.sv
// One cell of the square root chain: settles one root bit in every lane.
`timescale 1ns / 1ps
`default_nettype none

module rmpq_root_cell import rmpq_pkg::*; #(
  parameter int unsigned NW = 30,
  parameter int unsigned RW = 15,
  parameter int unsigned BIT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [LANES-1:0][NW-1:0]      in_rem,
  input  logic [LANES-1:0][RW-1:0]      in_root,
  output logic                          out_valid,
  output logic [LANES-1:0][NW-1:0]      out_rem,
  output logic [LANES-1:0][RW-1:0]      out_root
);

  localparam int unsigned XW = 2 * RW + 2;

  logic [LANES-1:0][NW-1:0] rem_next;
  logic [LANES-1:0][RW-1:0] root_next;
  logic [LANES-1:0][XW-1:0] trial;

  // The remainder holds n - r*r; setting bit BIT adds r*2^(BIT+1) + 2^(2*BIT).
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l] = (XW'(in_root[l]) << (BIT + 1)) + (XW'(1) << (2 * BIT));
      if (XW'(in_rem[l]) >= trial[l]) begin
        rem_next[l]  = NW'(XW'(in_rem[l]) - trial[l]);
        root_next[l] = in_root[l] | (RW'(1) << BIT);
      end else begin
        rem_next[l]  = in_rem[l];
        root_next[l] = in_root[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= rem_next;
    out_root <= root_next;
  end

endmodule

`default_nettype wire

>>> design/rotation_matrix_to_pose_quaternion_unit.sv
// Top level of the rotation matrix to pose quaternion unit.
// A word passes the entry register, the root cells and the output register from start to done.
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// Each root bit is resolved in its own registered cell, so the chain length sets latency.
// Reset (rst, synchronous) clears the valid bits of every stage; no result is pending after it.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_pose_quaternion_unit import rmpq_pkg::*; #(
  parameter int unsigned MATRIX_FRAC_BITS = DEF_FRAC_BITS,
  parameter int unsigned SHIFT_WIDTH = DEF_SHIFT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [MAT_W-1:0]       m00,
  input  logic signed [MAT_W-1:0]       m01,
  input  logic signed [MAT_W-1:0]       m02,
  input  logic signed [MAT_W-1:0]       m10,
  input  logic signed [MAT_W-1:0]       m11,
  input  logic signed [MAT_W-1:0]       m12,
  input  logic signed [MAT_W-1:0]       m20,
  input  logic signed [MAT_W-1:0]       m21,
  input  logic signed [MAT_W-1:0]       m22,
  input  logic signed [SHIFT_WIDTH-1:0] shift_x,
  input  logic signed [SHIFT_WIDTH-1:0] shift_y,
  input  logic signed [SHIFT_WIDTH-1:0] shift_z,
  output logic                          done,
  output logic        [QW_W-1:0]        quat_w,
  output logic signed [QV_W-1:0]        quat_x,
  output logic signed [QV_W-1:0]        quat_y,
  output logic signed [QV_W-1:0]        quat_z,
  output logic signed [SHIFT_WIDTH-1:0] pos_x,
  output logic signed [SHIFT_WIDTH-1:0] pos_y,
  output logic signed [SHIFT_WIDTH-1:0] pos_z
);

  localparam int unsigned NW = nrad_w(MATRIX_FRAC_BITS);
  localparam int unsigned RW = root_w(MATRIX_FRAC_BITS);
  // Width that holds both a raw root and the saturation value one.
  localparam int unsigned CW = (RW > MATRIX_FRAC_BITS + 1) ? RW : MATRIX_FRAC_BITS + 1;
  localparam int unsigned EW = (CW > QV_W) ? CW : QV_W;
  localparam logic [CW-1:0] ONE_Q = CW'(1) << MATRIX_FRAC_BITS;
  localparam logic signed [SHIFT_WIDTH-1:0] S_MIN = {1'b1, {(SHIFT_WIDTH-1){1'b0}}};
  localparam logic signed [SHIFT_WIDTH-1:0] S_MAX = {1'b0, {(SHIFT_WIDTH-1){1'b1}}};

  // The unit never refuses a word: every stage moves forward every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Radicands for the four quaternion magnitudes, formed from the diagonal.
  logic [LANES-1:0][NW-1:0] rad;

  rmpq_radicand #(
    .FRAC_BITS(MATRIX_FRAC_BITS), .NEG_A(1'b0), .NEG_B(1'b0), .NEG_C(1'b0)
  ) u_rad_w (.a(m00), .b(m11), .c(m22), .n(rad[LANE_W]));

  rmpq_radicand #(
    .FRAC_BITS(MATRIX_FRAC_BITS), .NEG_A(1'b0), .NEG_B(1'b1), .NEG_C(1'b1)
  ) u_rad_x (.a(m00), .b(m11), .c(m22), .n(rad[LANE_X]));

  rmpq_radicand #(
    .FRAC_BITS(MATRIX_FRAC_BITS), .NEG_A(1'b1), .NEG_B(1'b0), .NEG_C(1'b1)
  ) u_rad_y (.a(m00), .b(m11), .c(m22), .n(rad[LANE_Y]));

  rmpq_radicand #(
    .FRAC_BITS(MATRIX_FRAC_BITS), .NEG_A(1'b1), .NEG_B(1'b1), .NEG_C(1'b0)
  ) u_rad_z (.a(m00), .b(m11), .c(m22), .n(rad[LANE_Z]));

  // Signs of the off-diagonal differences. A zero difference counts as positive,
  // so only the sign bit of the widened difference matters.
  logic signed [MAT_W:0] diff_x, diff_y, diff_z;
  logic                  neg_x, neg_y, neg_z;

  always_comb begin
    diff_x = (MAT_W + 1)'(m21) - (MAT_W + 1)'(m12);
    diff_y = (MAT_W + 1)'(m02) - (MAT_W + 1)'(m20);
    diff_z = (MAT_W + 1)'(m10) - (MAT_W + 1)'(m01);
    neg_x  = diff_x[MAT_W];
    neg_y  = diff_y[MAT_W];
    neg_z  = diff_z[MAT_W];
  end

  // The y translation is negated, with the most negative value saturating.
  logic signed [SHIFT_WIDTH-1:0] neg_shift_y;
  assign neg_shift_y = (shift_y == S_MIN) ? S_MAX : -shift_y;

  // Chain signals: index 0 is the entry register, index RW the last cell's output.
  logic                     vld_chain  [0:RW];
  logic [LANES-1:0][NW-1:0] rem_chain  [0:RW];
  logic [LANES-1:0][RW-1:0] root_chain [0:RW];

  // Side data that rides along with each word, one register per stage.
  logic [2:0]                    sgn_chain [0:RW];
  logic signed [SHIFT_WIDTH-1:0] px_chain  [0:RW];
  logic signed [SHIFT_WIDTH-1:0] py_chain  [0:RW];
  logic signed [SHIFT_WIDTH-1:0] pz_chain  [0:RW];

  // Entry register: the radicands seed the remainders and the roots start at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_chain[0] <= 1'b0;
    end else begin
      vld_chain[0] <= accept;
    end
    rem_chain[0]  <= rad;
    root_chain[0] <= '0;
    sgn_chain[0]  <= {neg_z, neg_y, neg_x};
    px_chain[0]   <= shift_x;
    py_chain[0]   <= neg_shift_y;
    pz_chain[0]   <= shift_z;
  end

  // The cell chain resolves the root from its top bit down, one bit per cell.
  for (genvar k = 0; k < RW; k++) begin : g_cell
    rmpq_root_cell #(
      .NW(NW), .RW(RW), .BIT(RW - 1 - k)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .in_valid(vld_chain[k]),
      .in_rem(rem_chain[k]),
      .in_root(root_chain[k]),
      .out_valid(vld_chain[k+1]),
      .out_rem(rem_chain[k+1]),
      .out_root(root_chain[k+1])
    );

    always_ff @(posedge clk) begin
      sgn_chain[k+1] <= sgn_chain[k];
      px_chain[k+1]  <= px_chain[k];
      py_chain[k+1]  <= py_chain[k];
      pz_chain[k+1]  <= pz_chain[k];
    end
  end

  // Output stage: saturate each magnitude at one, apply the difference signs and
  // the handedness change (x and z negated), then truncate to the port widths.
  logic [LANES-1:0][CW-1:0]   q_sat;
  logic [LANES-1:0][EW-1:0]   q_ext;
  logic [LANES-1:0][QV_W-1:0] q_lo;
  logic signed [QV_W-1:0]     qx_next, qy_next, qz_next;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_sat[l] = (CW'(root_chain[RW][l]) > ONE_Q) ? ONE_Q : CW'(root_chain[RW][l]);
      q_ext[l] = EW'(q_sat[l]);
      q_lo[l]  = q_ext[l][QV_W-1:0];
    end
    // A negative difference flips the sign, and handedness flips x and z again.
    qx_next = sgn_chain[RW][0] ? q_lo[LANE_X] : -q_lo[LANE_X];
    qy_next = sgn_chain[RW][1] ? -q_lo[LANE_Y] : q_lo[LANE_Y];
    qz_next = sgn_chain[RW][2] ? q_lo[LANE_Z] : -q_lo[LANE_Z];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_chain[RW];
    end
    quat_w <= q_ext[LANE_W][QW_W-1:0];
    quat_x <= qx_next;
    quat_y <= qy_next;
    quat_z <= qz_next;
    pos_x  <= px_chain[RW];
    pos_y  <= py_chain[RW];
    pos_z  <= pz_chain[RW];
  end

endmodule

`default_nettype wire

>>> tb/sv/pose_quat_checker.sv
// Checker for the pose quaternion unit: predicts each result word and compares it.
`timescale 1ns / 1ps

module pose_quat_checker import rmpq_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS,
  parameter int unsigned SHIFT_W = DEF_SHIFT_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [MAT_W-1:0]   m00,
  input  logic signed [MAT_W-1:0]   m01,
  input  logic signed [MAT_W-1:0]   m02,
  input  logic signed [MAT_W-1:0]   m10,
  input  logic signed [MAT_W-1:0]   m11,
  input  logic signed [MAT_W-1:0]   m12,
  input  logic signed [MAT_W-1:0]   m20,
  input  logic signed [MAT_W-1:0]   m21,
  input  logic signed [MAT_W-1:0]   m22,
  input  logic signed [SHIFT_W-1:0] shift_x,
  input  logic signed [SHIFT_W-1:0] shift_y,
  input  logic signed [SHIFT_W-1:0] shift_z,
  input  logic                      done,
  input  logic        [QW_W-1:0]    quat_w,
  input  logic signed [QV_W-1:0]    quat_x,
  input  logic signed [QV_W-1:0]    quat_y,
  input  logic signed [QV_W-1:0]    quat_z,
  input  logic signed [SHIFT_W-1:0] pos_x,
  input  logic signed [SHIFT_W-1:0] pos_y,
  input  logic signed [SHIFT_W-1:0] pos_z,
  output int                        fail_count,
  output int                        outstanding,
  output int                        checked
);

  localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = {1'b1, {(SHIFT_W-1){1'b0}}};
  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = ~SHIFT_MIN;
  localparam longint ONE = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic        [QW_W-1:0]    w;
    logic signed [QV_W-1:0]    x;
    logic signed [QV_W-1:0]    y;
    logic signed [QV_W-1:0]    z;
    logic signed [SHIFT_W-1:0] px;
    logic signed [SHIFT_W-1:0] py;
    logic signed [SHIFT_W-1:0] pz;
  } pose_t;

  pose_t expected_poses[$];
  int    errors = 0;
  int    matched = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    checked     = 0;
  end

  // Truncated sqrt((ONE + d) / ONE) / 2 in the matrix format, clamped at zero and at ONE.
  function automatic logic [QW_W-1:0] half_root(input longint d);
    longint s;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    s = ONE + d;
    if (s <= 0) return '0;
    rem  = longint'(s) << (FRAC_BITS - 2);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (root > longint'(ONE)) root = ONE;
    return root[QW_W-1:0];
  endfunction

  function automatic pose_t predict_pose(
    input logic signed [MAT_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
    input logic signed [SHIFT_W-1:0] sx, sy, sz
  );
    pose_t p;
    longint d00, d01, d02, d10, d11, d12, d20, d21, d22;
    logic signed [QV_W-1:0] vx, vy, vz;
    d00 = a00; d01 = a01; d02 = a02;
    d10 = a10; d11 = a11; d12 = a12;
    d20 = a20; d21 = a21; d22 = a22;
    p.w = half_root(d00 + d11 + d22);
    vx  = {1'b0, half_root(d00 - d11 - d22)};
    vy  = {1'b0, half_root(-d00 + d11 - d22)};
    vz  = {1'b0, half_root(-d00 - d11 + d22)};
    // A zero difference keeps the positive sign.
    if (d21 - d12 < 0) vx = -vx;
    if (d02 - d20 < 0) vy = -vy;
    if (d10 - d01 < 0) vz = -vz;
    // The x and z parts flip to change handedness.
    p.x  = -vx;
    p.y  = vy;
    p.z  = -vz;
    p.px = sx;
    p.py = (sy == SHIFT_MIN) ? SHIFT_MAX : -sy;
    p.pz = sz;
    return p;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pose_t want;
    if (!rst) begin
      if ($isunknown(done)) begin
        errors++;
        $display("%0t: done strobe is unknown", $time);
      end else if (done) begin
        if (expected_poses.size() == 0) begin
          errors++;
          $display("%0t: result word with no matrix outstanding", $time);
        end else begin
          want = expected_poses.pop_front();
          check_field("quat_w", {49'd0, want.w}, {49'd0, quat_w});
          check_field("quat_x", want.x, quat_x);
          check_field("quat_y", want.y, quat_y);
          check_field("quat_z", want.z, quat_z);
          check_field("pos_x", want.px, pos_x);
          check_field("pos_y", want.py, pos_y);
          check_field("pos_z", want.pz, pos_z);
          matched++;
        end
      end
      if (start && !busy)
        expected_poses.insert(expected_poses.size(),
                              predict_pose(m00, m01, m02, m10, m11, m12, m20, m21, m22,
                                           shift_x, shift_y, shift_z));
    end
    fail_count  <= errors;
    outstanding <= expected_poses.size();
    checked     <= matched;
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the pose quaternion testbench: clock, reset, matrix stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import rmpq_pkg::*;

  localparam int SHIFT_W = DEF_SHIFT_W;
  localparam int RANDOM_WORDS = 1630;
  // The drain wait is far longer than the block's path from start to done.
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;

  logic signed [MAT_W-1:0] m00 = '0, m01 = '0, m02 = '0;
  logic signed [MAT_W-1:0] m10 = '0, m11 = '0, m12 = '0;
  logic signed [MAT_W-1:0] m20 = '0, m21 = '0, m22 = '0;
  logic signed [SHIFT_W-1:0] shift_x = '0, shift_y = '0, shift_z = '0;

  logic        [QW_W-1:0]    quat_w;
  logic signed [QV_W-1:0]    quat_x, quat_y, quat_z;
  logic signed [SHIFT_W-1:0] pos_x, pos_y, pos_z;

  int fail_count;
  int outstanding;
  int checked;

  // When set, the sender issues words back to back with no gaps.
  bit burst_mode = 1'b0;
  int words_sent = 0;
  int directed_words = 0;
  int rot[9];

  rotation_matrix_to_pose_quaternion_unit u_dut (
    .clk, .rst, .start, .busy,
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .shift_x, .shift_y, .shift_z,
    .done, .quat_w, .quat_x, .quat_y, .quat_z, .pos_x, .pos_y, .pos_z
  );

  // The checker sits beside the block and sees exactly the same ports.
  pose_quat_checker u_checker (
    .clk, .rst, .start, .busy,
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .shift_x, .shift_y, .shift_z,
    .done, .quat_w, .quat_x, .quat_y, .quat_z, .pos_x, .pos_y, .pos_z,
    .fail_count, .outstanding, .checked
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit: the slowest correct run takes well under a tenth of this.
  initial begin
    #4_000_000;
    $display("FAIL rotation_matrix_to_pose_quaternion_unit");
    $finish;
  end

  // Presents one word and holds it until the block takes it. Between words the
  // sender idles for a random number of cycles, unless a burst is running.
  task automatic drive_word(input int a00, a01, a02, a10, a11, a12, a20, a21, a22,
                            input int sx, sy, sz);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    start   <= 1'b1;
    m00     <= a00[MAT_W-1:0]; m01 <= a01[MAT_W-1:0]; m02 <= a02[MAT_W-1:0];
    m10     <= a10[MAT_W-1:0]; m11 <= a11[MAT_W-1:0]; m12 <= a12[MAT_W-1:0];
    m20     <= a20[MAT_W-1:0]; m21 <= a21[MAT_W-1:0]; m22 <= a22[MAT_W-1:0];
    shift_x <= sx[SHIFT_W-1:0];
    shift_y <= sy[SHIFT_W-1:0];
    shift_z <= sz[SHIFT_W-1:0];
    do @(posedge clk); while (busy !== 1'b0);
    words_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int to_q14(input real v);
    return $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
  endfunction

  function automatic real unit_draw();
    return (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
  endfunction

  // Builds a proper rotation from a random unit quaternion. Components are
  // sometimes forced to zero so that axis-aligned turns with equal off-diagonal
  // pairs come up often; a little noise is sometimes added to the entries.
  task automatic fill_rotation();
    real qw, qx, qy, qz, norm;
    qw = ($urandom_range(0, 4) == 0) ? 0.0 : unit_draw();
    qx = ($urandom_range(0, 4) == 0) ? 0.0 : unit_draw();
    qy = ($urandom_range(0, 4) == 0) ? 0.0 : unit_draw();
    qz = ($urandom_range(0, 4) == 0) ? 0.0 : unit_draw();
    norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (norm < 0.001) begin
      qw = 1.0; qx = 0.0; qy = 0.0; qz = 0.0; norm = 1.0;
    end
    qw = qw / norm; qx = qx / norm; qy = qy / norm; qz = qz / norm;
    rot[0] = to_q14(1.0 - 2.0 * (qy * qy + qz * qz));
    rot[1] = to_q14(2.0 * (qx * qy - qz * qw));
    rot[2] = to_q14(2.0 * (qx * qz + qy * qw));
    rot[3] = to_q14(2.0 * (qx * qy + qz * qw));
    rot[4] = to_q14(1.0 - 2.0 * (qx * qx + qz * qz));
    rot[5] = to_q14(2.0 * (qy * qz - qx * qw));
    rot[6] = to_q14(2.0 * (qx * qz - qy * qw));
    rot[7] = to_q14(2.0 * (qy * qz + qx * qw));
    rot[8] = to_q14(1.0 - 2.0 * (qx * qx + qy * qy));
    if ($urandom_range(0, 3) == 0) begin
      foreach (rot[i]) rot[i] = rot[i] + $urandom_range(0, 4) - 2;
    end
  endtask

  // Translation values: mostly random over the full width, now and then an extreme.
  function automatic int draw_shift();
    case ($urandom_range(0, 39))
      0: return -8388608;
      1: return 8388607;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  initial begin
    int kind;
    int ent[9];
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words. Identity, and the half turns about each axis where every
    // off-diagonal difference is zero and so the sign stays positive.
    drive_word(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0);
    drive_word(16384, 0, 0, 0, -16384, 0, 0, 0, -16384, 256, -256, 512);
    drive_word(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384, -1, 1, 0);
    drive_word(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384, 8388607, 8388607, 8388607);
    // Quarter turns in both directions about x, y and z exercise both signs.
    drive_word(16384, 0, 0, 0, 0, -16384, 0, 16384, 0, 100, 200, 300);
    drive_word(16384, 0, 0, 0, 0, 16384, 0, -16384, 0, -100, -200, -300);
    drive_word(0, 0, 16384, 0, 16384, 0, -16384, 0, 0, 1, 2, 3);
    drive_word(0, 0, -16384, 0, 16384, 0, 16384, 0, 0, -3, -2, -1);
    drive_word(0, -16384, 0, 16384, 0, 0, 0, 0, 16384, 7, 8, 9);
    drive_word(0, 16384, 0, -16384, 0, 0, 0, 0, 16384, -7, -8, -9);
    // All zero: every radicand is exactly one.
    drive_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // All at plus one: the scalar part reaches one exactly, the others vanish.
    drive_word(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 0, 0, 0);
    // All at minus one: the scalar radicand goes negative and clamps to zero.
    drive_word(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384,
               0, 0, 0);
    // Extreme entries push the radicands out of range: some magnitudes saturate at one, others clamp to zero.
    drive_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
               8388607, -8388608, -8388608);
    drive_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
               -8388608, 8388607, 8388607);
    drive_word(32767, -32768, 32767, -32768, -32768, 32767, 32767, -32768, 32767,
               -8388608, -8388608, 0);
    // Radicand exactly zero for the scalar part.
    drive_word(-16384, 0, 0, 0, 0, 0, 0, 0, 0, 0, -8388608, 0);
    // Radicand one count below zero and one count above it.
    drive_word(-16385, 5, -5, 5, 0, -5, 5, 5, 0, 0, -8388607, 0);
    drive_word(-16383, -5, 5, -5, 0, 5, -5, -5, 0, 0, 1, 0);
    // Differences of one count either way.
    drive_word(8192, 1, 0, 0, 8192, 0, 1, 0, 8192, 0, -1, 0);
    drive_word(8192, 0, 0, 1, 8192, 1, 0, 0, 8192, 0, 0, 0);
    directed_words = words_sent;

    // Random part, in groups of 64 words; each group is chosen at random to be a burst or to have random gaps.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        fill_rotation();
        ent = rot;
      end else if (kind < 85) begin
        foreach (ent[i]) ent[i] = $urandom_range(0, 32768) - 16384;
      end else begin
        foreach (ent[i]) ent[i] = int'($urandom);
      end
      drive_word(ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7], ent[8],
                 draw_shift(), draw_shift(), draw_shift());
    end
    start <= 1'b0;

    // Wait for the last results, then watch a while longer for stray strobes.
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;

    $display("Sent %0d matrix words (%0d directed, the rest random rotations and raw",
             words_sent, directed_words);
    $display("patterns) and checked %0d quaternion and translation results.", checked);
    if (fail_count == 0) begin
      $display("PASS rotation_matrix_to_pose_quaternion_unit");
    end else begin
      $display("FAIL rotation_matrix_to_pose_quaternion_unit");
    end
    $finish;
  end

endmodule
